### hdl/rgb_to_hsv_8bit_macros.svh
// ----------------------------------------------------------------------------
// rgb_to_hsv_8bit_macros.svh
// Assertion macros shared by the RGB to HSV converter.
// They compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_8BIT_MACROS_SVH
`define RGB_TO_HSV_8BIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled while reset is low
`define RTH_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rgb_to_hsv_8bit: assertion failed");
// next-cycle implication, disabled while reset is low
`define RTH_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rgb_to_hsv_8bit: assertion failed");
`else
`define RTH_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RTH_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### hdl/rth_pkg.sv
// ----------------------------------------------------------------------------
// rth_pkg
// Widths, types and constants of the RGB to HSV converter.
// ----------------------------------------------------------------------------
package rth_pkg;

    // pixel channel width
    localparam int PixW = 8;
    // dividend width: 255 * span needs 16 bits
    localparam int DvdW = 2 * PixW;

    // divider pipeline: quotient bits resolved per stage
    localparam int DivBitsPerStage = 2;
    localparam int DivStages       = PixW / DivBitsPerStage;

    // conversion constants
    localparam int SatFull     = 255;
    localparam int HueSector   = 43;
    localparam int HueOfsRed   = 0;
    localparam int HueOfsGreen = 85;
    localparam int HueOfsBlue  = 171;

    typedef logic [PixW-1:0] t_pix;
    typedef logic [DvdW-1:0] t_dvd;

    // per-item sideband that rides along the divider stages
    typedef struct packed {
        t_pix mx;    // brightness
        logic gray;  // all channels equal
        logic neg;   // hue term is negative
        t_pix ofs;   // sector offset
    } t_side;

endpackage

### hdl/rth_div.sv
// ----------------------------------------------------------------------------
// rth_div
// Pipelined restoring divider, unsigned, with a quotient known to fit in
// PixW bits. DivBitsPerStage quotient bits are resolved per stage, MSB first.
// ----------------------------------------------------------------------------
module rth_div (
    input  logic                            i_clk,
    input  logic [rth_pkg::DivStages-1:0]   i_en,
    input  rth_pkg::t_dvd                   i_dividend,
    input  rth_pkg::t_pix                   i_divisor,
    output rth_pkg::t_pix                   o_quotient
);
    import rth_pkg::*;

    t_dvd r_rem [DivStages];
    t_pix r_dvs [DivStages];
    t_pix r_quo [DivStages];

    genvar j;
    generate
        for (j = 0; j < DivStages; j++) begin : g_stage
            t_dvd          rem_in;
            t_pix          dvs_in;
            t_pix          quo_in;
            t_dvd          n_rem;
            t_pix          n_quo;
            logic [DvdW:0] trial;

            // stage inputs: the dividend for the first stage, else the previous stage
            if (j == 0) begin : g_first
                assign rem_in = i_dividend;
                assign dvs_in = i_divisor;
                assign quo_in = '0;
            end else begin : g_next
                assign rem_in = r_rem[j-1];
                assign dvs_in = r_dvs[j-1];
                assign quo_in = r_quo[j-1];
            end

            // trial subtract of the shifted divisor, one quotient bit per step
            always_comb begin
                n_rem = rem_in;
                n_quo = quo_in;
                trial = '0;
                for (int s = 0; s < DivBitsPerStage; s++) begin
                    trial = {1'b0, n_rem}
                          - ((DvdW+1)'(dvs_in) << (PixW - 1 - j * DivBitsPerStage - s));
                    if (!trial[DvdW]) begin
                        n_rem = trial[DvdW-1:0];
                    end
                    n_quo = {n_quo[PixW-2:0], ~trial[DvdW]};
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en[j]) begin
                    r_rem[j] <= n_rem;
                    r_dvs[j] <= dvs_in;
                    r_quo[j] <= n_quo;
                end
            end
        end
    endgenerate

    assign o_quotient = r_quo[DivStages-1];

endmodule

### hdl/rgb_to_hsv_8bit.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_8bit
// Converts one 8-bit RGB pixel per item to 8-bit hue, saturation and value.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_ready with i_red, i_green, i_blue. An item is
// taken on a rising edge with both high.
// Output channel: o_valid / i_ready with o_hue, o_saturation, o_brightness.
// Each item gives exactly one result, in order.
// Throughput: one item per cycle while the output does not stall. The depth
// is set by the two dividers (saturation and hue term), four stages of two
// quotient bits each, plus a sort stage, a scaling stage and the output
// register.
// Every stage has its own valid bit; a stage loads whenever it is empty or
// the stage after it moves, so bubbles close up while the output stalls.
// When i_ready stays low the result is held in the output register and
// o_ready falls only once all seven stages are full. Nothing is lost or
// repeated.
// Reset (synchronous, active low) clears all valid bits; the data registers
// are not reset.
// ----------------------------------------------------------------------------
`include "rgb_to_hsv_8bit_macros.svh"

module rgb_to_hsv_8bit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  rth_pkg::t_pix i_red,
    input  rth_pkg::t_pix i_green,
    input  rth_pkg::t_pix i_blue,
    output logic          o_valid,
    input  logic          i_ready,
    output rth_pkg::t_pix o_hue,
    output rth_pkg::t_pix o_saturation,
    output rth_pkg::t_pix o_brightness
);
    import rth_pkg::*;

    // stage positions
    localparam int NStg   = DivStages + 3;
    localparam int StgA   = 0;
    localparam int StgB   = 1;
    localparam int StgD0  = 2;
    localparam int StgOut = NStg - 1;

    logic [NStg-1:0] r_vld;
    logic [NStg-1:0] stage_en;

    // load enables: a stage moves when empty or when its successor moves
    always_comb begin
        stage_en[StgOut] = !r_vld[StgOut] || i_ready;
        for (int k = StgOut - 1; k >= 0; k--) begin
            stage_en[k] = !r_vld[k] || stage_en[k+1];
        end
    end

    assign o_ready = stage_en[StgA];
    assign o_valid = r_vld[StgOut];

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_en[StgA]) begin
                r_vld[StgA] <= i_valid;
            end
            for (int k = 1; k < NStg; k++) begin
                if (stage_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ---------------- stage A: max, min, sector ----------------
    t_pix                n_a_mx;
    t_pix                n_a_mn;
    t_pix                n_a_ofs;
    logic signed [PixW:0] n_a_diff;
    t_pix                r_a_mx;
    t_pix                r_a_mn;
    t_pix                r_a_ofs;
    logic signed [PixW:0] r_a_diff;

    always_comb begin
        // red wins ties, then green
        if (i_red >= i_green && i_red >= i_blue) begin
            n_a_mx   = i_red;
            n_a_ofs  = PixW'(HueOfsRed);
            n_a_diff = $signed({1'b0, i_green}) - $signed({1'b0, i_blue});
        end else if (i_green >= i_blue) begin
            n_a_mx   = i_green;
            n_a_ofs  = PixW'(HueOfsGreen);
            n_a_diff = $signed({1'b0, i_blue}) - $signed({1'b0, i_red});
        end else begin
            n_a_mx   = i_blue;
            n_a_ofs  = PixW'(HueOfsBlue);
            n_a_diff = $signed({1'b0, i_red}) - $signed({1'b0, i_green});
        end
        n_a_mn = (i_red < i_green) ? i_red : i_green;
        if (i_blue < n_a_mn) begin
            n_a_mn = i_blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[StgA]) begin
            r_a_mx   <= n_a_mx;
            r_a_mn   <= n_a_mn;
            r_a_ofs  <= n_a_ofs;
            r_a_diff <= n_a_diff;
        end
    end

    // ---------------- stage B: span and dividends ----------------
    t_pix          b_span;
    logic [PixW:0] b_mag_full;
    t_pix          b_mag;
    t_dvd          r_b_sat_dvd;
    t_dvd          r_b_hue_dvd;
    t_pix          r_b_mx;
    t_pix          r_b_span;
    t_side         r_b_side;

    assign b_span     = r_a_mx - r_a_mn;
    assign b_mag_full = r_a_diff[PixW] ? (~r_a_diff + 1'b1) : r_a_diff;
    assign b_mag      = b_mag_full[PixW-1:0];

    always_ff @(posedge i_clk) begin
        if (stage_en[StgB]) begin
            r_b_sat_dvd   <= DvdW'(b_span) * DvdW'(SatFull);
            r_b_hue_dvd   <= DvdW'(b_mag) * DvdW'(HueSector);
            r_b_mx        <= r_a_mx;
            r_b_span      <= b_span;
            r_b_side.mx   <= r_a_mx;
            r_b_side.gray <= (b_span == '0);
            r_b_side.neg  <= r_a_diff[PixW];
            r_b_side.ofs  <= r_a_ofs;
        end
    end

    // ---------------- dividers ----------------
    t_pix sat_quo;
    t_pix hue_quo;

    rth_div u_sat_div (
        .i_clk      (i_clk),
        .i_en       (stage_en[StgD0 +: DivStages]),
        .i_dividend (r_b_sat_dvd),
        .i_divisor  (r_b_mx),
        .o_quotient (sat_quo)
    );

    rth_div u_hue_div (
        .i_clk      (i_clk),
        .i_en       (stage_en[StgD0 +: DivStages]),
        .i_dividend (r_b_hue_dvd),
        .i_divisor  (r_b_span),
        .o_quotient (hue_quo)
    );

    // sideband delay matching the divider stages
    t_side r_side [DivStages];

    always_ff @(posedge i_clk) begin
        if (stage_en[StgD0]) begin
            r_side[0] <= r_b_side;
        end
        for (int k = 1; k < DivStages; k++) begin
            if (stage_en[StgD0 + k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // ---------------- output stage: hue sum and masking ----------------
    t_side side_d;
    t_pix  hue_term;
    t_pix  n_hue;
    t_pix  n_sat;
    t_pix  r_hue;
    t_pix  r_sat;
    t_pix  r_val;

    assign side_d   = r_side[DivStages-1];
    assign hue_term = side_d.neg ? PixW'(~hue_quo + 1'b1) : hue_quo;

    always_comb begin
        // black forces gray, so hue goes to zero with it
        n_hue = side_d.gray ? '0 : PixW'(side_d.ofs + hue_term);
        n_sat = (side_d.mx == '0) ? '0 : sat_quo;
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[StgOut]) begin
            r_hue <= n_hue;
            r_sat <= n_sat;
            r_val <= side_d.mx;
        end
    end

    assign o_hue        = r_hue;
    assign o_saturation = r_sat;
    assign o_brightness = r_val;

    // ---------------- checks ----------------
    `RTH_ASSERT_IMP(a_black_zero, i_clk, i_rst_n, o_valid && (o_brightness == '0), (o_hue == '0) && (o_saturation == '0))
    `RTH_ASSERT_IMP(a_gray_hue, i_clk, i_rst_n, o_valid && (o_saturation == '0), o_hue == '0)
    `RTH_ASSERT_IMP(a_full_stall, i_clk, i_rst_n, !o_ready, &r_vld)
    `RTH_ASSERT_NXT(a_out_fill, i_clk, i_rst_n, !r_vld[StgOut] && r_vld[StgOut-1], o_valid)

endmodule

### test/tb_rgb_to_hsv_8bit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_to_hsv_8bit
// Self-checking bench for the 8-bit RGB to HSV converter.
// Pixels go in over valid/ready. Each accepted pixel is converted by an
// integer HSV model, and its result is queued. Each result taken from the
// output is compared field by field with the oldest queued result.
// A directed set covers black, gray, primaries, ties for the maximum and
// hue wrap. Random pixels then run under three idle patterns on both sides.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsv_8bit;
    import rth_pkg::*;

    localparam int CycleLimit = 200000;
    localparam int DrainCycles = 16;

    typedef struct packed {
        t_pix hue;
        t_pix sat;
        t_pix val;
    } t_hsv;

    // Scoreboard: converts accepted pixels and checks results in order
    class hsv_scoreboard;
        t_hsv pending_hsv[$];
        int   errors;

        function new();
            errors = 0;
        endfunction

        // integer HSV of one pixel; the hue term truncates toward zero
        function t_hsv convert_pixel(t_pix r, t_pix g, t_pix b);
            int   mx;
            int   mn;
            int   span;
            int   sat_full;
            int   hue_full;
            t_hsv res;
            mx = int'(r);
            if (int'(g) > mx) mx = int'(g);
            if (int'(b) > mx) mx = int'(b);
            mn = int'(r);
            if (int'(g) < mn) mn = int'(g);
            if (int'(b) < mn) mn = int'(b);
            if (mx == 0) begin
                res = '0;
                return res;
            end
            span = mx - mn;
            sat_full = (SatFull * span) / mx;
            // red wins ties, then green
            if (sat_full == 0 || span == 0) begin
                hue_full = 0;
            end else if (mx == int'(r)) begin
                hue_full = HueOfsRed + (HueSector * (int'(g) - int'(b))) / span;
            end else if (mx == int'(g)) begin
                hue_full = HueOfsGreen + (HueSector * (int'(b) - int'(r))) / span;
            end else begin
                hue_full = HueOfsBlue + (HueSector * (int'(r) - int'(g))) / span;
            end
            // hue wraps modulo 256
            res.hue = t_pix'(hue_full);
            res.sat = t_pix'(sat_full);
            res.val = t_pix'(mx);
            return res;
        endfunction

        function void note_pixel(t_pix r, t_pix g, t_pix b);
            pending_hsv = {pending_hsv, convert_pixel(r, g, b)};
        endfunction

        function void check_result(t_pix hue, t_pix sat, t_pix val);
            t_hsv want;
            if (pending_hsv.size() == 0) begin
                $error("unexpected result: hue %0d saturation %0d brightness %0d",
                       hue, sat, val);
                errors++;
                return;
            end
            want = pending_hsv.pop_front();
            if (hue !== want.hue) begin
                $error("hue: expected %0d, got %0d", want.hue, hue);
                errors++;
            end
            if (sat !== want.sat) begin
                $error("saturation: expected %0d, got %0d", want.sat, sat);
                errors++;
            end
            if (val !== want.val) begin
                $error("brightness: expected %0d, got %0d", want.val, val);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_hsv.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_pix i_red;
    t_pix i_green;
    t_pix i_blue;
    logic o_valid;
    logic i_ready;
    t_pix o_hue;
    t_pix o_saturation;
    t_pix o_brightness;

    hsv_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycles = 0;

    rgb_to_hsv_8bit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_brightness (o_brightness)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("FAIL rgb_to_hsv_8bit");
            $finish;
        end
    end

    // receiver: random stalls, changed at the falling edge
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result check at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result(o_hue, o_saturation, o_brightness);
        end
    end

    // Send one pixel; called and returns at a falling edge
    task automatic send_pixel(input t_pix r, input t_pix g, input t_pix b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_red   <= r;
        i_green <= g;
        i_blue  <= b;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        sb.note_pixel(r, g, b);
        @(negedge i_clk);
    endtask

    // channel value: mostly anything, sometimes an extreme
    function automatic t_pix pick_channel();
        case ($urandom_range(9))
            0: return t_pix'(0);
            1: return t_pix'(255);
            2: return t_pix'($urandom_range(1, 3));
            default: return t_pix'($urandom());
        endcase
    endfunction

    // Random pixel mix: free, ties between two channels, gray, near-gray
    task automatic send_random(input int count);
        t_pix r;
        t_pix g;
        t_pix b;
        t_pix m;
        for (int n = 0; n < count; n++) begin
            r = pick_channel();
            g = pick_channel();
            b = pick_channel();
            case ($urandom_range(9))
                0: begin
                    g = r;
                end
                1: begin
                    b = g;
                end
                2: begin
                    b = r;
                end
                3: begin
                    g = r;
                    b = r;
                end
                4: begin
                    // small span around a common level
                    m = t_pix'($urandom());
                    r = m ^ t_pix'($urandom_range(3));
                    g = m ^ t_pix'($urandom_range(3));
                    b = m ^ t_pix'($urandom_range(3));
                end
                default: begin
                end
            endcase
            send_pixel(r, g, b);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_red   = '0;
        i_green = '0;
        i_blue  = '0;
        i_ready = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: black, gray, primaries, ties, hue wrap, extremes
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd1,   8'd1,   8'd1);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd255);
        send_pixel(8'd200, 8'd200, 8'd17);
        send_pixel(8'd255, 8'd0,   8'd128);
        send_pixel(8'd255, 8'd254, 8'd254);
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'd0,   8'd1,   8'd0);
        send_pixel(8'd0,   8'd0,   8'd1);
        send_pixel(8'd1,   8'd1,   8'd0);
        send_pixel(8'd2,   8'd1,   8'd1);
        send_pixel(8'd170, 8'd85,  8'd255);
        send_pixel(8'd85,  8'd170, 8'd0);
        send_pixel(8'd254, 8'd1,   8'd127);
        send_pixel(8'd128, 8'd127, 8'd129);

        // random: sender idles 22, receiver 57
        send_idle_pct = 22;
        recv_idle_pct = 57;
        send_random(160);
        // swapped
        send_idle_pct = 57;
        recv_idle_pct = 22;
        send_random(160);
        // no idling
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(160);
        i_valid <= 1'b0;

        // drain
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("PASS rgb_to_hsv_8bit");
        end else begin
            $display("FAIL rgb_to_hsv_8bit");
        end
        $finish;
    end

endmodule
